[rtl/mask_cell_and_border_lister_defines.svh]
// ----------------------------------------------------------------------------
// Mask cell and border lister assertion macros
// Shared assertion forms for the checker of the lister.
// ----------------------------------------------------------------------------
`ifndef MASK_CELL_AND_BORDER_LISTER_DEFINES_SVH
`define MASK_CELL_AND_BORDER_LISTER_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define MCBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define MCBL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/mcbl_pkg.sv]
// ----------------------------------------------------------------------------
// Mask cell and border lister package
// Grid size, coordinate widths, scan phase codes, handshake structs and the
// row mask helper functions shared by the lister modules.
// ----------------------------------------------------------------------------
package mcbl_pkg;

    localparam int GRID    = 8;
    localparam int IN_W    = 8;
    localparam int COORD_W = 5;
    localparam int ROW_W   = 4;
    // Border rows span the frame column on each side of the mask.
    localparam int BW      = GRID + 2;
    localparam int IDX_W   = $clog2(BW);
    localparam int NPH     = 4;
    localparam int PH_W    = 2;

    localparam logic [PH_W-1:0] PH_CELL  = 2'd0;
    localparam logic [PH_W-1:0] PH_ABOVE = 2'd1;
    localparam logic [PH_W-1:0] PH_MID   = 2'd2;
    localparam logic [PH_W-1:0] PH_BELOW = 2'd3;

    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_BORDER = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pend_any;
        logic final_one;
    } dp_status_t;

    // Row as a frame-padded vector: bit i holds column i-1.
    function automatic logic [BW-1:0] ext_row(input logic [IN_W-1:0] b);
        logic [GRID+IN_W-1:0] w;
        logic [BW-1:0]        r;
        w = {{GRID{1'b0}}, b};
        r = '0;
        for (int i = 0; i < GRID; i++) begin
            r[i+1] = w[i];
        end
        return r;
    endfunction

    // Cells that are clear and touch a set 4-neighbor.
    function automatic logic [BW-1:0] border_mask(input logic [BW-1:0] above,
                                                  input logic [BW-1:0] mid,
                                                  input logic [BW-1:0] below);
        return (above | below | (mid << 1) | (mid >> 1)) & ~mid;
    endfunction

endpackage

[rtl/mcbl_ctrl.sv]
// ----------------------------------------------------------------------------
// Mask cell and border lister controller
// Sequences row loading and result emission and owns the result valid flag.
// ----------------------------------------------------------------------------
module mcbl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output mcbl_pkg::ctrl_cmd_t cmd,
    input  mcbl_pkg::dp_status_t status
);
    import mcbl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_LIST;
                end
            end
            ST_LIST: begin
                if (!status.pend_any) begin
                    state_next = ST_IDLE;
                end else if (cmd.emit && status.final_one) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_LIST: begin
                cmd.emit = status.pend_any && (!out_valid_reg || m_ready);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // The output register refills in the same cycle that its result transfers.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[rtl/mcbl_datapath.sv]
// ----------------------------------------------------------------------------
// Mask cell and border lister datapath
// Holds the row history, the pending cell and border masks of the current
// row, and the result register; picks the next coordinate each cycle.
// ----------------------------------------------------------------------------
module mcbl_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic        [mcbl_pkg::IN_W-1:0]    s_row_bits,
    input  mcbl_pkg::ctrl_cmd_t                 cmd,
    output mcbl_pkg::dp_status_t                status,
    output logic                                m_kind,
    output logic signed [mcbl_pkg::COORD_W-1:0] m_col,
    output logic signed [mcbl_pkg::COORD_W-1:0] m_row,
    output logic                                m_last
);
    import mcbl_pkg::*;

    logic [IN_W-1:0]  row_prev_reg;
    logic [IN_W-1:0]  row_before_prev_reg;
    logic [ROW_W-1:0] row_counter_reg;
    logic [ROW_W-1:0] item_y_reg;
    logic [BW-1:0]    pend_reg  [NPH];
    logic [BW-1:0]    pend_next [NPH];

    logic                      kind_reg;
    logic signed [COORD_W-1:0] col_reg;
    logic signed [COORD_W-1:0] row_reg;
    logic                      last_reg;

    logic                      last_row;
    logic [BW-1:0]             cur_ext;
    logic [BW-1:0]             prev_ext;
    logic [BW-1:0]             prev2_ext;
    logic [PH_W-1:0]           sel_ph;
    logic                      found;
    logic                      later_any;
    logic [BW-1:0]             sel_mask;
    logic [BW-1:0]             cleared;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] base_y;
    logic signed [COORD_W-1:0] sel_row;
    logic signed [COORD_W-1:0] sel_col;

    assign last_row  = (row_counter_reg == ROW_W'(GRID - 1));
    assign cur_ext   = ext_row(s_row_bits);
    assign prev_ext  = ext_row(row_prev_reg);
    assign prev2_ext = ext_row(row_before_prev_reg);

    // First phase with work left, then its lowest pending column.
    always_comb begin
        sel_ph    = PH_CELL;
        found     = 1'b0;
        later_any = 1'b0;
        for (int i = 0; i < NPH; i++) begin
            if (!found && pend_reg[i] != '0) begin
                sel_ph = PH_W'(i);
                found  = 1'b1;
            end
        end
        for (int i = 0; i < NPH; i++) begin
            if (PH_W'(i) > sel_ph && pend_reg[i] != '0) begin
                later_any = 1'b1;
            end
        end
        sel_mask = pend_reg[sel_ph];
        idx      = '0;
        for (int i = BW - 1; i >= 0; i--) begin
            if (sel_mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        cleared = sel_mask & ~(BW'(1) << idx);
    end

    assign status.pend_any  = found;
    assign status.final_one = (cleared == '0) && !later_any;

    assign base_y  = $signed({{(COORD_W - ROW_W){1'b0}}, item_y_reg});
    assign sel_col = $signed({{(COORD_W - IDX_W){1'b0}}, idx}) - COORD_W'(1);

    always_comb begin
        case (sel_ph)
            PH_CELL:  sel_row = base_y;
            PH_ABOVE: sel_row = base_y - COORD_W'(1);
            PH_MID:   sel_row = base_y;
            PH_BELOW: sel_row = base_y + COORD_W'(1);
            default:  sel_row = base_y;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NPH; i++) begin
            pend_next[i] = pend_reg[i];
        end
        if (cmd.load) begin
            pend_next[PH_CELL]  = cur_ext;
            pend_next[PH_ABOVE] = border_mask(prev2_ext, prev_ext, cur_ext);
            pend_next[PH_MID]   = last_row ? border_mask(prev_ext, cur_ext, '0) : '0;
            pend_next[PH_BELOW] = last_row ? border_mask(cur_ext, '0, '0) : '0;
        end else if (cmd.emit) begin
            pend_next[sel_ph] = cleared;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_prev_reg        <= '0;
            row_before_prev_reg <= '0;
            row_counter_reg     <= '0;
            for (int i = 0; i < NPH; i++) begin
                pend_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NPH; i++) begin
                pend_reg[i] <= pend_next[i];
            end
            if (cmd.load) begin
                if (last_row) begin
                    row_prev_reg        <= '0;
                    row_before_prev_reg <= '0;
                    row_counter_reg     <= '0;
                end else begin
                    row_prev_reg        <= s_row_bits;
                    row_before_prev_reg <= row_prev_reg;
                    row_counter_reg     <= row_counter_reg + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_y_reg <= row_counter_reg;
        end
        if (cmd.emit) begin
            kind_reg <= (sel_ph == PH_CELL) ? KIND_CELL : KIND_BORDER;
            col_reg  <= sel_col;
            row_reg  <= sel_row;
            last_reg <= (cleared == '0) && !later_any;
        end
    end

    assign m_kind = kind_reg;
    assign m_col  = col_reg;
    assign m_row  = row_reg;
    assign m_last = last_reg;

endmodule

[rtl/mask_cell_and_border_lister.sv]
// A row transfer loads the pending masks; the result register then takes
// the first pick. One result per cycle unless m_ready stalls the output;
// a row holds the input until the single result selector picks its last
// result (0 to 26). A row without results still enters the listing state.
// Reset (aresetn low at a clock edge) clears the row history, the row
// counter, the pending masks and the result valid flag.
// ----------------------------------------------------------------------------
// Mask cell and border lister
// Lists set cells of each mask row and every clear cell with a set 4-neighbor.
// ----------------------------------------------------------------------------
module mask_cell_and_border_lister (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [mcbl_pkg::IN_W-1:0]    s_row_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic signed [mcbl_pkg::COORD_W-1:0] m_col,
    output logic signed [mcbl_pkg::COORD_W-1:0] m_row,
    output logic                                m_last
);
    import mcbl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mcbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    mcbl_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_row_bits (s_row_bits),
        .cmd        (cmd),
        .status     (status),
        .m_kind     (m_kind),
        .m_col      (m_col),
        .m_row      (m_row),
        .m_last     (m_last)
    );

endmodule

[rtl/mcbl_checker.sv]
// ----------------------------------------------------------------------------
// Mask cell and border lister checker
// Port level assertions on the lister, bound to its top level.
// ----------------------------------------------------------------------------
`include "mask_cell_and_border_lister_defines.svh"

module mcbl_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_kind,
    input logic signed [mcbl_pkg::COORD_W-1:0] m_col,
    input logic signed [mcbl_pkg::COORD_W-1:0] m_row,
    input logic                                m_last
);
    import mcbl_pkg::*;

    // A stalled result keeps its payload.
    `MCBL_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_col) && $stable(m_row) && $stable(m_kind) && $stable(m_last), "stalled result changed")

    `MCBL_ASSERT_RST(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")

    // A row transfer always occupies the lister for at least the next cycle.
    `MCBL_ASSERT(a_busy_after_load, s_valid && s_ready |=> !s_ready, "input taken twice in a row")

    `MCBL_ASSERT(a_col_range, m_valid |-> m_col >= -1 && m_col <= GRID && m_row >= -1 && m_row <= GRID, "coordinate outside frame")

    `MCBL_ASSERT(a_cell_inside, m_valid && m_kind == KIND_CELL |-> m_col >= 0 && m_col < GRID && m_row >= 0 && m_row < GRID, "set cell outside mask")

endmodule

bind mask_cell_and_border_lister mcbl_checker u_mcbl_checker (.*);
